[src/skfc_pkg.sv]
// Shared types and constants of the seen-key FIFO cache.
`default_nettype none
package skfc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned HASH_W          = 4 * WORD_W;
  localparam int unsigned INDEX_W         = 32;
  localparam int unsigned KEY_W           = HASH_W + INDEX_W;
  localparam int unsigned KEEP_W          = 10;
  localparam int unsigned ACTION_W        = 2;

  localparam logic [KEEP_W-1:0] KEEP_LIMIT_RESET = KEEP_W'(1000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_QUERY = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_ADD   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_WRITE
  } state_e;

endpackage
`default_nettype wire

[src/skfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skfc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[src/skfc_ctrl.sv]
// Sequencer of the cache: ring scan with one shared key comparator, eviction and insert.
`default_nettype none
module skfc_ctrl #(
  parameter int unsigned TableDepth = skfc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [skfc_pkg::ACTION_W-1:0]     action_i,
  input  wire logic                              update_i,
  input  wire logic [skfc_pkg::KEY_W-1:0]        key_i,
  input  wire logic [skfc_pkg::HASH_W-1:0]       value_i,
  input  wire logic [skfc_pkg::KEEP_W-1:0]       keep_limit_i,
  output logic      [$clog2(TableDepth)-1:0]     raddr_o,
  input  wire logic [skfc_pkg::KEY_W-1:0]        key_rdata_i,
  input  wire logic [skfc_pkg::HASH_W-1:0]       val_rdata_i,
  output logic      [$clog2(TableDepth)-1:0]     waddr_o,
  output logic                                   key_we_o,
  output logic                                   val_we_o,
  output logic      [skfc_pkg::KEY_W-1:0]        key_wdata_o,
  output logic      [skfc_pkg::HASH_W-1:0]       val_wdata_o,
  output logic                                   done_o,
  output logic                                   verdict_o,
  output logic                                   found_o,
  output logic      [skfc_pkg::HASH_W-1:0]       stored_o
);
  import skfc_pkg::*;

  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned CmpW  = (CntW > KEEP_W) ? CntW : KEEP_W;

  localparam logic [CntW-1:0]  CntFull  = CntW'(TableDepth);
  localparam logic [CntW-1:0]  CntMax   = CntW'(TableDepth - 1);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(TableDepth - 1);
  localparam logic [SumW-1:0]  SumDepth = SumW'(TableDepth);

  // Reduces a sum of two ring positions, known to be below twice the depth.
  function automatic logic [SlotW-1:0] ring_wrap(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = (s >= SumDepth) ? (s - SumDepth) : s;
    return r[SlotW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [ACTION_W-1:0] action_q, action_d;
  logic              update_q, update_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [HASH_W-1:0] value_q, value_d;
  logic [SlotW-1:0]  oldest_q, oldest_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [SlotW-1:0]  rd_slot_q, rd_slot_d;
  logic [SlotW-1:0]  cmp_slot_q, cmp_slot_d;
  logic              pend_q, pend_d;
  logic [SlotW-1:0]  hit_slot_q, hit_slot_d;
  logic              found_q, found_d;
  logic              verdict_q, verdict_d;
  logic [HASH_W-1:0] stored_q, stored_d;
  logic              done_q, done_d;

  logic              match;
  logic              issue;
  logic [CmpW-1:0]   keep_cap;
  logic [CntW-1:0]   kept;
  logic [CntW-1:0]   evict_n;
  logic [SlotW-1:0]  append_slot;

  assign match = pend_q && (key_rdata_i == key_q);
  assign issue = (rd_idx_q < count_q);

  // Entries left before a checked insert: min(count, limit, depth - 1).
  always_comb begin
    keep_cap = CmpW'(keep_limit_i);
    if (keep_cap > CmpW'(CntMax)) begin
      keep_cap = CmpW'(CntMax);
    end
    if (CmpW'(count_q) < keep_cap) begin
      kept = count_q;
    end else begin
      kept = keep_cap[CntW-1:0];
    end
  end

  assign evict_n     = count_q - kept;
  assign append_slot = ring_wrap(SumW'(oldest_q) + SumW'(count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      oldest_q <= '0;
      count_q  <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    update_q   <= update_d;
    key_q      <= key_d;
    value_q    <= value_d;
    rd_idx_q   <= rd_idx_d;
    rd_slot_q  <= rd_slot_d;
    cmp_slot_q <= cmp_slot_d;
    hit_slot_q <= hit_slot_d;
    found_q    <= found_d;
    verdict_q  <= verdict_d;
    stored_q   <= stored_d;
  end

  always_comb begin
    state_d    = state_q;
    action_d   = action_q;
    update_d   = update_q;
    key_d      = key_q;
    value_d    = value_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_slot_d  = rd_slot_q;
    cmp_slot_d = cmp_slot_q;
    pend_d     = 1'b0;
    hit_slot_d = hit_slot_q;
    found_d    = found_q;
    verdict_d  = verdict_q;
    stored_d   = stored_q;
    done_d     = 1'b0;
    raddr_o    = rd_slot_q;
    waddr_o    = found_q ? hit_slot_q : append_slot;
    key_we_o   = 1'b0;
    val_we_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          action_d  = action_i;
          update_d  = update_i;
          key_d     = key_i;
          value_d   = value_i;
          rd_idx_d  = '0;
          rd_slot_d = oldest_q;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          found_d    = 1'b1;
          stored_d   = val_rdata_i;
          hit_slot_d = cmp_slot_q;
          unique case (action_q)
            ACT_CHECK: begin
              verdict_d = (val_rdata_i == value_q);
              done_d    = 1'b1;
              state_d   = ST_IDLE;
            end
            ACT_ADD: begin
              verdict_d = 1'b1;
              state_d   = ST_WRITE;
            end
            default: begin
              verdict_d = 1'b0;
              done_d    = 1'b1;
              state_d   = ST_IDLE;
            end
          endcase
        end else if (!issue) begin
          // Every live entry has been compared without a hit.
          found_d   = 1'b0;
          stored_d  = '0;
          verdict_d = 1'b1;
          unique case (action_q)
            ACT_CHECK: begin
              if (update_q) begin
                state_d = ST_EVICT;
              end else begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
            ACT_ADD: begin
              if (count_q == CntFull) begin
                verdict_d = 1'b0;
                done_d    = 1'b1;
                state_d   = ST_IDLE;
              end else begin
                state_d = ST_WRITE;
              end
            end
            default: begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end else begin
          pend_d     = 1'b1;
          cmp_slot_d = rd_slot_q;
          rd_idx_d   = rd_idx_q + 1'b1;
          rd_slot_d  = (rd_slot_q == SlotLast) ? '0 : (rd_slot_q + 1'b1);
        end
      end
      ST_EVICT: begin
        oldest_d = ring_wrap(SumW'(oldest_q) + SumW'(evict_n));
        count_d  = kept;
        state_d  = ST_WRITE;
      end
      ST_WRITE: begin
        val_we_o = 1'b1;
        key_we_o = !found_q;
        if (!found_q) begin
          count_d = count_q + 1'b1;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign key_wdata_o = key_q;
  assign val_wdata_o = value_q;
  assign done_o      = done_q;
  assign verdict_o   = verdict_q;
  assign found_o     = found_q;
  assign stored_o    = stored_q;

endmodule
`default_nettype wire

[src/seen_key_fifo_cache_top.sv]
// Top level of the seen-key FIFO cache: ports, keep-limit register and slot memories.
`default_nettype none
// An exact-match table from a 288-bit key (256-bit hash plus 32-bit index)
// to a 256-bit value, kept as a ring in insertion order with first-in
// first-out eviction. A word is accepted on a clock edge where start is high
// and busy is low. The block then compares the stored keys one per cycle,
// oldest first, through a single key comparator fed by the registered read
// port of the key memory, and stops at the first hit. An insert or an
// overwrite then takes a write step, and a checked insert an eviction step
// before that. The result word is shown for exactly one cycle, marked by
// done_o, and must be taken in that cycle: the receiver cannot stall the
// block. busy stays high until that strobe cycle, so a new word may be
// started in the very cycle the previous result is shown. The memories need
// no clearing after reset; only live ring slots are ever read. The
// keep-limit register is always ready; the user must write it only while
// the block is idle, which the block itself does not enforce.
module seen_key_fifo_cache_top #(
  parameter int unsigned TableDepth = skfc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [skfc_pkg::ACTION_W-1:0] action_i,
  input  wire logic                          update_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   key_hash_0_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   key_hash_1_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   key_hash_2_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   key_hash_3_i,
  input  wire logic [skfc_pkg::INDEX_W-1:0]  key_index_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   block_hash_0_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   block_hash_1_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   block_hash_2_i,
  input  wire logic [skfc_pkg::WORD_W-1:0]   block_hash_3_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [skfc_pkg::KEEP_W-1:0]   cfg_data_i,
  output logic                               done_o,
  output logic                               verdict_o,
  output logic                               found_o,
  output logic      [skfc_pkg::WORD_W-1:0]   stored_hash_0_o,
  output logic      [skfc_pkg::WORD_W-1:0]   stored_hash_1_o,
  output logic      [skfc_pkg::WORD_W-1:0]   stored_hash_2_o,
  output logic      [skfc_pkg::WORD_W-1:0]   stored_hash_3_o
);
  import skfc_pkg::*;

  localparam int unsigned SlotW = $clog2(TableDepth);

  logic [KEEP_W-1:0] keep_limit_q;

  logic [KEY_W-1:0]  key_in;
  logic [HASH_W-1:0] value_in;
  logic [SlotW-1:0]  raddr;
  logic [SlotW-1:0]  waddr;
  logic              key_we;
  logic              val_we;
  logic [KEY_W-1:0]  key_rdata;
  logic [KEY_W-1:0]  key_wdata;
  logic [HASH_W-1:0] val_rdata;
  logic [HASH_W-1:0] val_wdata;
  logic [HASH_W-1:0] stored;

  // The cfg channel never stalls; writes must only arrive while idle (unenforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= KEEP_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      keep_limit_q <= cfg_data_i;
    end
  end

  // The key is stored as one wide word: the index above the four hash words.
  assign key_in   = {key_index_i, key_hash_3_i, key_hash_2_i, key_hash_1_i, key_hash_0_i};
  assign value_in = {block_hash_3_i, block_hash_2_i, block_hash_1_i, block_hash_0_i};

  skfc_ram #(
    .Width (KEY_W),
    .Depth (TableDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  skfc_ram #(
    .Width (HASH_W),
    .Depth (TableDepth)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  // The sequencer owns the ring pointers and the shared key comparator.
  skfc_ctrl #(
    .TableDepth (TableDepth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .action_i     (action_i),
    .update_i     (update_i),
    .key_i        (key_in),
    .value_i      (value_in),
    .keep_limit_i (keep_limit_q),
    .raddr_o      (raddr),
    .key_rdata_i  (key_rdata),
    .val_rdata_i  (val_rdata),
    .waddr_o      (waddr),
    .key_we_o     (key_we),
    .val_we_o     (val_we),
    .key_wdata_o  (key_wdata),
    .val_wdata_o  (val_wdata),
    .done_o       (done_o),
    .verdict_o    (verdict_o),
    .found_o      (found_o),
    .stored_o     (stored)
  );

  assign stored_hash_0_o = stored[0*WORD_W +: WORD_W];
  assign stored_hash_1_o = stored[1*WORD_W +: WORD_W];
  assign stored_hash_2_o = stored[2*WORD_W +: WORD_W];
  assign stored_hash_3_o = stored[3*WORD_W +: WORD_W];

endmodule
`default_nettype wire
